// ----- rtl/text_glyph_layout_aligner_defines.svh -----
// assertion macros for the text glyph layout aligner
// used by the top level; expects clk and rst_n in scope
`ifndef TEXT_GLYPH_LAYOUT_ALIGNER_DEFINES_SVH
`define TEXT_GLYPH_LAYOUT_ALIGNER_DEFINES_SVH

// same-cycle implication
`define TGLA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TGLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tgla_pkg.sv -----
// shared types and constants of the text glyph layout aligner
// no dependencies
`default_nettype none

package tgla_pkg;

  localparam int POS_W         = 20;
  localparam int CHAR_W        = 7;
  localparam int SLOT_W        = 7;
  localparam int GLYPH_ENTRIES = 95;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_FIRST   = 8'd32;
  localparam logic [7:0] CHAR_LAST    = 8'd126;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_H    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_V    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 3'd5;

  typedef struct packed {
    logic [7:0]        advance;
    logic signed [7:0] offset_y;
    logic signed [7:0] offset_x;
  } glyph_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [CHAR_W-1:0]       c;
  } place_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/tgla_in_if.sv -----
// input channel: glyph table loads and characters
// depends on tgla_pkg
`default_nettype none

interface tgla_in_if import tgla_pkg::*;;
  logic              valid;
  logic              ready;
  logic              op;
  logic [SLOT_W-1:0] glyph_slot;
  logic signed [7:0] glyph_offset_x;
  logic signed [7:0] glyph_offset_y;
  logic [7:0]        glyph_advance;
  logic [7:0]        char_code;

  modport source (
    output valid, op, glyph_slot, glyph_offset_x, glyph_offset_y, glyph_advance, char_code,
    input  ready
  );
  modport sink (
    input  valid, op, glyph_slot, glyph_offset_x, glyph_offset_y, glyph_advance, char_code,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tgla_out_if.sv -----
// result channel: placed glyph positions
// depends on tgla_pkg
`default_nettype none

interface tgla_out_if import tgla_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] place_x;
  logic signed [POS_W-1:0] place_y;
  logic [CHAR_W-1:0]       placed_char;
  logic                    line_last;
  logic                    line_overflow;

  modport source (
    output valid, place_x, place_y, placed_char, line_last, line_overflow,
    input  ready
  );
  modport sink (
    input  valid, place_x, place_y, placed_char, line_last, line_overflow,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/text_glyph_layout_aligner.sv -----
// text_glyph_layout_aligner: top level, config, pen state, glyph table and line buffer cells
// depends on tgla_pkg, tgla_in_if, tgla_out_if, tgla_glyph_table, tgla_cell, defines header
// printable character: table read, alignment multiply, then place; load or ignored: handled in idle
// newline or NUL: drains each buffered glyph in turn, cells shift toward the output each step
// first position is registered from the head cell in the drain state, then one per cycle unless out_ch stalls
// synchronous active-low reset clears config (line count resets to 1), pen, fill count and table valid bits
`default_nettype none
`include "text_glyph_layout_aligner_defines.svh"

module text_glyph_layout_aligner import tgla_pkg::*; #(
  parameter int LINE_CAPACITY = 64,
  parameter int FRAC_BITS     = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  tgla_in_if.sink                   in_ch,
  tgla_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int FILL_W  = $clog2(LINE_CAPACITY + 1);
  localparam int WIDE_W  = 24 + FRAC_BITS;
  localparam int VSHIFT  = 8 - FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] POS_HI = WIDE_W'((2 ** (POS_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] POS_LO = -POS_HI - WIDE_W'(1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MUL   = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = v;
    if (v > POS_HI) c = POS_HI;
    if (v < POS_LO) c = POS_LO;
    return POS_W'(c);
  endfunction

  logic signed [15:0]       origin_x_r, origin_y_r;
  logic [8:0]               align_h_r, align_v_r;
  logic [7:0]               pitch_r;
  logic [9:0]               line_count_r;

  logic [1:0]               state_r;
  logic [FILL_W-1:0]        fill_r;
  logic                     ovf_r;
  logic signed [POS_W-1:0]  pen_x_r, pen_y_r;
  logic [CHAR_W-1:0]        char_r;
  logic [17:0]              prod_a_r;
  logic [26:0]              prod_b_r;
  logic signed [29:0]       shift_prod_r;

  logic                     out_valid_r;
  place_t                   out_data_r;
  logic                     out_last_r;
  logic                     out_ovf_r;

  logic                     in_xfer, is_load, is_print, is_flush, slot_ok;
  logic                     store_ok, place_go, drain_go;
  logic [SLOT_W-1:0]        rd_addr;
  glyph_t                   wr_glyph, glyph;
  place_t                   new_place;
  place_t                   cell_q [LINE_CAPACITY];
  logic signed [WIDE_W-1:0] px_w, py_w, adv_x_w, nl_y_w, drain_x_w;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      align_h_r    <= '0;
      align_v_r    <= '0;
      pitch_r      <= '0;
      line_count_r <= 10'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:   origin_x_r   <= cfg_data;
        CFG_ORIGIN_Y:   origin_y_r   <= cfg_data;
        CFG_ALIGN_H:    align_h_r    <= cfg_data[8:0];
        CFG_ALIGN_V:    align_v_r    <= cfg_data[8:0];
        CFG_LINE_PITCH: pitch_r      <= cfg_data[7:0];
        CFG_LINE_COUNT: line_count_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // input decode
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign is_load     = (in_ch.op == OP_LOAD);
  assign is_print    = (in_ch.op == OP_CHAR) && (in_ch.char_code >= CHAR_FIRST)
                       && (in_ch.char_code <= CHAR_LAST);
  assign is_flush    = (in_ch.op == OP_CHAR) && ((in_ch.char_code == CHAR_NEWLINE)
                       || (in_ch.char_code == CHAR_NUL));
  assign slot_ok     = (in_ch.glyph_slot < SLOT_W'(GLYPH_ENTRIES));
  assign rd_addr     = SLOT_W'(in_ch.char_code - CHAR_FIRST);

  assign wr_glyph.advance  = in_ch.glyph_advance;
  assign wr_glyph.offset_y = in_ch.glyph_offset_y;
  assign wr_glyph.offset_x = in_ch.glyph_offset_x;

  tgla_glyph_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_xfer && is_load && slot_ok),
    .wr_addr (in_ch.glyph_slot),
    .wr_data (wr_glyph),
    .rd_en   (in_xfer && is_print),
    .rd_addr (rd_addr),
    .rd_data (glyph)
  );

  // placement and pen arithmetic
  always_comb begin
    px_w = (WIDE_W'(origin_x_r) <<< FRAC_BITS) + WIDE_W'(pen_x_r)
         + (WIDE_W'(glyph.offset_x) <<< FRAC_BITS);
    py_w = (WIDE_W'(origin_y_r) <<< FRAC_BITS) + WIDE_W'(pen_y_r)
         + (WIDE_W'(glyph.offset_y) <<< FRAC_BITS)
         - $signed(WIDE_W'(prod_b_r >> VSHIFT));
    adv_x_w   = WIDE_W'(pen_x_r) + ($signed(WIDE_W'({1'b0, glyph.advance})) <<< FRAC_BITS);
    nl_y_w    = WIDE_W'(pen_y_r) + ($signed(WIDE_W'({1'b0, pitch_r})) <<< FRAC_BITS);
    drain_x_w = WIDE_W'(cell_q[0].x) - WIDE_W'(shift_prod_r >>> 8);
    new_place.x = sat_pos(px_w);
    new_place.y = sat_pos(py_w);
    new_place.c = char_r;
  end

  assign store_ok = (fill_r < FILL_W'(LINE_CAPACITY));
  assign place_go = (state_r == S_PLACE);
  assign drain_go = (state_r == S_DRAIN) && (!out_valid_r || out_ch.ready);

  // line buffer cells, head at index 0
  for (genvar k = 0; k < LINE_CAPACITY; k++) begin : g_cell
    cell_ctl_t ctl;
    place_t    next_data;
    assign ctl.shift = drain_go;
    assign ctl.load  = place_go && store_ok && (fill_r == FILL_W'(k));
    if (k == LINE_CAPACITY - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_body
      assign next_data = cell_q[k+1];
    end
    tgla_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_data (new_place),
      .next_data (next_data),
      .data      (cell_q[k])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer && is_print) state_r <= S_MUL;
          if (in_xfer && is_flush) begin
            pen_x_r <= '0;
            if (in_ch.char_code == CHAR_NEWLINE) begin
              pen_y_r <= sat_pos(nl_y_w);
            end else begin
              pen_y_r <= '0;
            end
            if (fill_r != '0) state_r <= S_DRAIN;
          end
        end
        S_MUL: begin
          state_r <= S_PLACE;
        end
        S_PLACE: begin
          if (store_ok) begin
            fill_r <= fill_r + FILL_W'(1);
          end else begin
            ovf_r <= 1'b1;
          end
          pen_x_r <= sat_pos(adv_x_w);
          state_r <= S_IDLE;
        end
        S_DRAIN: begin
          if (drain_go) begin
            fill_r <= fill_r - FILL_W'(1);
            if (fill_r == FILL_W'(1)) begin
              ovf_r   <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (drain_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer && is_print) begin
      char_r   <= in_ch.char_code[CHAR_W-1:0];
      prod_a_r <= line_count_r * pitch_r;
    end
    if (in_xfer && is_flush) shift_prod_r <= pen_x_r * $signed({1'b0, align_h_r});
    if (state_r == S_MUL) prod_b_r <= prod_a_r * align_v_r;
    if (drain_go) begin
      out_data_r.x <= sat_pos(drain_x_w);
      out_data_r.y <= cell_q[0].y;
      out_data_r.c <= cell_q[0].c;
      out_last_r   <= (fill_r == FILL_W'(1));
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.place_x       = out_data_r.x;
  assign out_ch.place_y       = out_data_r.y;
  assign out_ch.placed_char   = out_data_r.c;
  assign out_ch.line_last     = out_last_r;
  assign out_ch.line_overflow = out_ovf_r;

  `TGLA_ASSERT(a_ovf_full, ovf_r && (state_r != S_DRAIN), fill_r == FILL_W'(LINE_CAPACITY), "overflow flag with buffer not full")
  `TGLA_ASSERT(a_drain_nonempty, state_r == S_DRAIN, fill_r != '0, "drain with empty buffer")
  `TGLA_ASSERT_NEXT(a_last_done, drain_go && (fill_r == FILL_W'(1)), (state_r == S_IDLE) && (fill_r == '0) && !ovf_r, "line not closed after last glyph")

endmodule

`default_nettype wire

// ----- rtl/tgla_glyph_table.sv -----
// glyph metrics table: 95-entry memory with registered read and per-entry valid bits
// depends on tgla_pkg
`default_nettype none

module tgla_glyph_table import tgla_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [SLOT_W-1:0] wr_addr,
  input  wire glyph_t            wr_data,
  input  wire logic              rd_en,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output glyph_t                 rd_data
);

  glyph_t                   mem [GLYPH_ENTRIES];
  logic [GLYPH_ENTRIES-1:0] valid_r;
  glyph_t                   rd_r;
  logic                     hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      if (rd_en) hit_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[rd_addr];
  end

  // entries never loaded read as zero
  assign rd_data = hit_r ? rd_r : '0;

endmodule

`default_nettype wire

// ----- rtl/tgla_cell.sv -----
// one line buffer cell: holds a placed glyph, loads from placement, shifts from its neighbor
// depends on tgla_pkg
`default_nettype none

module tgla_cell import tgla_pkg::*; (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire place_t    load_data,
  input  wire place_t    next_data,
  output place_t         data
);

  place_t data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= next_data;
    end else if (ctl.load) begin
      data_r <= load_data;
    end
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ----- verif/text_glyph_layout_aligner_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for text_glyph_layout_aligner: glyph loads, text lines and flushes
// drives tgla_in_if and tgla_out_if from the rtl, predicts placed positions in the bench
// depends on tgla_pkg, tgla_in_if, tgla_out_if and the top level

module text_glyph_layout_aligner_tb;
  import tgla_pkg::*;

  localparam int LINE_CAPACITY = 64;
  localparam int FRAC_BITS = 4;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint POS_HI = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_LO = -(longint'(1) << (POS_W - 1));
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic signed [7:0] ox;
    logic signed [7:0] oy;
    logic [7:0]        adv;
    logic [7:0]        code;
  } text_item_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [CHAR_W-1:0]       c;
    logic                    last;
    logic                    ovf;
  } due_place_t;

  typedef struct {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [8:0]         ah;
    logic [8:0]         av;
    logic [7:0]         pitch;
    logic [9:0]         count;
  } layout_cfg_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  tgla_in_if in_ch ();
  tgla_out_if out_ch ();

  text_glyph_layout_aligner dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // layout state kept by the bench
  glyph_t glyph_rom [GLYPH_ENTRIES];
  longint pen_x, pen_y;
  place_t line_buf [$];
  bit line_dropped;
  longint org_x, org_y;
  int align_h, align_v, pitch, line_count;

  due_place_t placements_due [$];

  int errors = 0;
  int items_sent = 0;
  int positions_checked = 0;
  int overflow_positions = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;

  function automatic longint clamp_pos(longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic void reset_layout();
    foreach (glyph_rom[i]) glyph_rom[i] = '0;
    pen_x = 0;
    pen_y = 0;
    line_buf.delete();
    line_dropped = 1'b0;
    org_x = 0;
    org_y = 0;
    align_h = 0;
    align_v = 0;
    pitch = 0;
    line_count = 1;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_ORIGIN_X:   org_x = longint'($signed(data));
      CFG_ORIGIN_Y:   org_y = longint'($signed(data));
      CFG_ALIGN_H:    align_h = int'(data[8:0]);
      CFG_ALIGN_V:    align_v = int'(data[8:0]);
      CFG_LINE_PITCH: pitch = int'(data[7:0]);
      CFG_LINE_COUNT: line_count = int'(data[9:0]);
      default: ;
    endcase
  endfunction

  // place, buffer or flush as one accepted item demands
  function automatic void advance_layout(text_item_t it);
    glyph_t g;
    place_t p;
    due_place_t d;
    longint vshift, hshift;
    int n;
    if (it.op == OP_LOAD) begin
      if (it.slot < GLYPH_ENTRIES) glyph_rom[it.slot] = {it.adv, it.oy, it.ox};
      return;
    end
    if (it.code >= CHAR_FIRST && it.code <= CHAR_LAST) begin
      g = glyph_rom[it.code - CHAR_FIRST];
      vshift = (longint'(line_count) * pitch * align_v) >>> (8 - FRAC_BITS);
      if (line_buf.size() < LINE_CAPACITY) begin
        p.x = POS_W'(clamp_pos(org_x * ONE + pen_x + longint'($signed(g.offset_x)) * ONE));
        p.y = POS_W'(clamp_pos(org_y * ONE + pen_y + longint'($signed(g.offset_y)) * ONE
                               - vshift));
        p.c = it.code[CHAR_W-1:0];
        line_buf.push_back(p);
      end else begin
        line_dropped = 1'b1;
      end
      pen_x = clamp_pos(pen_x + longint'(g.advance) * ONE);
    end else if (it.code == CHAR_NEWLINE || it.code == CHAR_NUL) begin
      hshift = (pen_x * align_h) >>> 8;
      n = line_buf.size();
      for (int k = 0; k < n; k++) begin
        d.x = POS_W'(clamp_pos(longint'($signed(line_buf[k].x)) - hshift));
        d.y = line_buf[k].y;
        d.c = line_buf[k].c;
        d.last = (k == n - 1);
        d.ovf = line_dropped;
        placements_due.push_back(d);
      end
      line_buf.delete();
      line_dropped = 1'b0;
      pen_x = 0;
      if (it.code == CHAR_NEWLINE) pen_y = clamp_pos(pen_y + longint'(pitch) * ONE);
      else pen_y = 0;
    end
  endfunction

  function automatic text_item_t char_item(logic [7:0] code);
    text_item_t it;
    it.op = OP_CHAR;
    it.slot = $urandom_range(0, 127);
    it.ox = $urandom_range(0, 255);
    it.oy = $urandom_range(0, 255);
    it.adv = $urandom_range(0, 255);
    it.code = code;
    return it;
  endfunction

  function automatic text_item_t load_item(logic [SLOT_W-1:0] slot, logic signed [7:0] ox,
                                           logic signed [7:0] oy, logic [7:0] adv);
    text_item_t it;
    it.op = OP_LOAD;
    it.slot = slot;
    it.ox = ox;
    it.oy = oy;
    it.adv = adv;
    it.code = $urandom_range(0, 255);
    return it;
  endfunction

  function automatic logic [7:0] stray_code();
    case ($urandom_range(0, 2))
      0: return $urandom_range(1, 9);
      1: return $urandom_range(11, 31);
      default: return $urandom_range(127, 255);
    endcase
  endfunction

  task automatic send_item(text_item_t it);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.glyph_slot <= it.slot;
    in_ch.glyph_offset_x <= it.ox;
    in_ch.glyph_offset_y <= it.oy;
    in_ch.glyph_advance <= it.adv;
    in_ch.char_code <= it.code;
    do @(posedge clk); while (!in_ch.ready);
    advance_layout(it);
    items_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(char_item(s[i]));
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves the write enable high; callers lower it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic program_layout(layout_cfg_t s);
    settle_block();
    write_reg(CFG_ORIGIN_X, s.ox);
    write_reg(CFG_ORIGIN_Y, s.oy);
    write_reg(CFG_ALIGN_H, {7'd0, s.ah});
    write_reg(CFG_ALIGN_V, {7'd0, s.av});
    write_reg(CFG_LINE_PITCH, {8'd0, s.pitch});
    write_reg(CFG_LINE_COUNT, {6'd0, s.count});
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_cases();
    layout_cfg_t s;
    // reset settings first
    send_item(load_item(7'd0, -8'sd128, 8'sd127, 8'd255));
    send_item(load_item(7'd94, 8'sd127, -8'sd128, 8'd0));
    send_item(load_item(7'd95, 8'sd5, 8'sd5, 8'd5));
    send_item(load_item(7'd127, -8'sd1, -8'sd1, 8'd255));
    send_item(char_item(CHAR_LAST));
    send_item(char_item(CHAR_FIRST));
    send_item(char_item(8'd65));
    send_item(char_item(8'd1));
    send_item(char_item(8'd9));
    send_item(char_item(8'd11));
    send_item(char_item(8'd31));
    send_item(char_item(8'd127));
    send_item(char_item(8'd128));
    send_item(char_item(8'd255));
    send_item(char_item(CHAR_NEWLINE));
    send_item(char_item(CHAR_NEWLINE));
    send_item(char_item(CHAR_FIRST));
    send_item(char_item(CHAR_NUL));
    send_item(char_item(CHAR_NUL));
    // extreme settings: far left, far down, full alignment
    s = '{ox: -16'sd32768, oy: 16'sd32767, ah: 9'd256, av: 9'd256, pitch: 8'd255,
          count: 10'd1023};
    program_layout(s);
    send_text("~ ~");
    send_item(char_item(CHAR_NEWLINE));
    send_item(char_item(CHAR_FIRST));
    send_item(char_item(CHAR_NUL));
  endtask

  task automatic test_midline_settings();
    layout_cfg_t s;
    s = '{ox: 16'sd10, oy: 16'sd20, ah: 9'd128, av: 9'd64, pitch: 8'd12, count: 10'd3};
    program_layout(s);
    send_item(load_item(7'd40, 8'sd2, -8'sd3, 8'd9));
    send_item(load_item(7'd73, -8'sd1, 8'sd4, 8'd5));
    send_text("Hi");
    // new origin and alignment with a line still buffered
    settle_block();
    write_reg(CFG_ORIGIN_X, -16'sd5);
    write_reg(CFG_ALIGN_H, 16'd256);
    cfg_we <= 1'b0;
    send_text("iH");
    send_item(char_item(CHAR_NEWLINE));
    send_text("H");
    send_item(char_item(CHAR_NUL));
  endtask

  task automatic test_line_overflow();
    layout_cfg_t s;
    logic [7:0] wide [3] = '{8'd35, 8'd77, 8'd87};
    s = '{ox: 16'sd32767, oy: -16'sd32768, ah: 9'd511, av: 9'd511, pitch: 8'd0, count: 10'd0};
    program_layout(s);
    foreach (wide[i])
      send_item(load_item(wide[i] - CHAR_FIRST, $urandom_range(0, 255), $urandom_range(0, 255),
                          8'd255));
    // exactly full line, no drop
    repeat (LINE_CAPACITY) send_item(char_item($urandom_range(32, 126)));
    send_item(char_item(CHAR_NEWLINE));
    // long enough to drop glyphs and pin the pen at its maximum
    repeat (130) send_item(char_item(wide[$urandom_range(0, 2)]));
    send_item(char_item(CHAR_NUL));
    send_item(char_item(wide[0]));
    send_item(char_item(CHAR_NEWLINE));
  endtask

  task automatic random_text_phase(int target);
    layout_cfg_t s;
    int counted;
    int len;
    int pick;
    counted = 0;
    s.ox = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400) - 200;
    s.oy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400) - 200;
    s.ah = $urandom_range(0, 511);
    s.av = $urandom_range(0, 511);
    s.pitch = $urandom_range(0, 255);
    s.count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 6);
    program_layout(s);
    while (counted < target) begin
      len = $urandom_range(0, 10);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          send_item(load_item($urandom_range(0, 127), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255)));
          counted++;
        end else if (pick < 18) begin
          send_item(char_item(stray_code()));
        end else begin
          send_item(char_item($urandom_range(32, 126)));
          counted++;
        end
      end
      send_item(char_item(($urandom_range(0, 4) == 0) ? CHAR_NUL : CHAR_NEWLINE));
      counted++;
    end
    send_item(char_item(CHAR_NUL));
  endtask

  task automatic test_random_text();
    repeat (3) random_text_phase(8);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    random_text_phase(8);
  endtask

  // result side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_positions
    due_place_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (placements_due.size() == 0) begin
        $error("unexpected position transfer: x %0d y %0d char %0d",
               out_ch.place_x, out_ch.place_y, out_ch.placed_char);
        errors++;
      end else begin
        want = placements_due.pop_front();
        positions_checked++;
        if (want.ovf) overflow_positions++;
        if (out_ch.place_x !== want.x) begin
          $error("place_x mismatch: expected %0d, actual %0d", want.x, out_ch.place_x);
          errors++;
        end
        if (out_ch.place_y !== want.y) begin
          $error("place_y mismatch: expected %0d, actual %0d", want.y, out_ch.place_y);
          errors++;
        end
        if (out_ch.placed_char !== want.c) begin
          $error("placed_char mismatch: expected %0d, actual %0d", want.c, out_ch.placed_char);
          errors++;
        end
        if (out_ch.line_last !== want.last) begin
          $error("line_last mismatch: expected %0d, actual %0d", want.last, out_ch.line_last);
          errors++;
        end
        if (out_ch.line_overflow !== want.ovf) begin
          $error("line_overflow mismatch: expected %0d, actual %0d", want.ovf,
                 out_ch.line_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d positions still due", quiet_cycles,
               placements_due.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_LOAD;
    in_ch.glyph_slot <= '0;
    in_ch.glyph_offset_x <= '0;
    in_ch.glyph_offset_y <= '0;
    in_ch.glyph_advance <= '0;
    in_ch.char_code <= '0;
    reset_layout();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_midline_settings();
    test_line_overflow();
    test_random_text();

    in_ch.valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items: glyph loads, printable and stray codes, empty and full lines",
             items_sent);
    $display("checked %0d positions, %0d of them on lines that dropped glyphs",
             positions_checked, overflow_positions);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tgla_pkg.sv
rtl/tgla_in_if.sv
rtl/tgla_out_if.sv
rtl/tgla_glyph_table.sv
rtl/tgla_cell.sv
rtl/text_glyph_layout_aligner.sv
verif/text_glyph_layout_aligner_tb.sv
